// ===== rtl/sntp_offset_filter_defines.svh =====
// ----------------------------------------------------------------------------
// sntp offset filter assertion macros
// checks used by the rtl file of the offset filter
// ----------------------------------------------------------------------------
`ifndef SNTP_OFFSET_FILTER_DEFINES_SVH
`define SNTP_OFFSET_FILTER_DEFINES_SVH

// same-cycle implication
`define SOF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sntp offset filter check failed");

// next-cycle implication
`define SOF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sntp offset filter check failed");

`endif

// ===== rtl/sof_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sof_pkg
// types, constants and helpers shared by the sntp offset filter
// ----------------------------------------------------------------------------
package sof_pkg;

    localparam int MAX_SAMPLES  = 5;
    localparam int SELECT_COUNT = 3;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int SEL_W  = $clog2(SELECT_COUNT + 1);
    localparam int SIDX_W = (SELECT_COUNT > 1) ? $clog2(SELECT_COUNT) : 1;

    localparam logic [63:0] MS_UNITS    = 64'd4294967;
    localparam logic [62:0] MAX63       = '1;
    localparam logic [2:0]  MODE_SERVER = 3'd4;
    localparam logic [2:0]  MIN_VERSION = 3'd3;
    localparam logic [1:0]  LEAP_ALARM  = 2'b11;
    localparam logic [7:0]  STRATUM_MAX = 8'd15;

    localparam logic [1:0] OP_CLEAR      = 2'd0;
    localparam logic [1:0] OP_REPLY      = 2'd1;
    localparam logic [1:0] OP_FINISH     = 2'd2;
    localparam logic [1:0] OP_FINISH_ALT = 2'd3;

    localparam logic [3:0] ST_STORED       = 4'd0;
    localparam logic [3:0] ST_BAD_HEADER   = 4'd1;
    localparam logic [3:0] ST_ORIG_MISMATCH = 4'd2;
    localparam logic [3:0] ST_ZERO_STAMPS  = 4'd3;
    localparam logic [3:0] ST_INCONSISTENT = 4'd4;
    localparam logic [3:0] ST_FULL         = 4'd5;
    localparam logic [3:0] ST_READY        = 4'd6;
    localparam logic [3:0] ST_NO_SAMPLES   = 4'd7;
    localparam logic [3:0] ST_CLEARED      = 4'd8;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  header_flags;
        logic [7:0]  stratum;
        logic [31:0] root_dispersion;
        logic [63:0] originate_stamp;
        logic [63:0] receive_stamp;
        logic [63:0] transmit_stamp;
        logic [63:0] local_send_time;
        logic [63:0] local_receive_time;
        logic [47:0] round_trip_time;
    } req_item_t;

    typedef struct packed {
        logic [3:0]         status;
        logic signed [63:0] clock_error;
        logic [62:0]        network_delay;
        logic [62:0]        uncertainty;
        logic [47:0]        best_round_trip;
        logic [2:0]         sample_count;
    } rsp_item_t;

    typedef struct packed {
        logic [63:0] offset;
        logic [62:0] delay;
        logic [47:0] dispersion;
        logic [47:0] round_trip;
    } sample_t;

    typedef struct packed {
        logic        sub;
        logic [64:0] a;
        logic [64:0] b;
    } alu_req_t;

    function automatic logic [64:0] sx(input logic [63:0] v);
        return {v[63], v};
    endfunction

    function automatic logic [64:0] zx(input logic [63:0] v);
        return {1'b0, v};
    endfunction

endpackage

// ===== rtl/sntp_offset_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sntp_offset_filter
// clock error and delay filter over checked sntp replies
// ----------------------------------------------------------------------------
// Every item is handled by a small sequencer that drives one shared 65-bit
// adder, one step per cycle unless held at the output, and the block takes
// no new item until the current one has reached the output register. A clear
// goes straight to the output; a reply passes through checks, four stamp
// differences, halving, negation and delay. A finish with n stored samples
// selects s = min(3, n) by a one-entry-per-cycle delay scan and sorts them
// by compare-and-swap through the same adder. A result waiting on the output
// does not stop the next item being accepted, but that item waits to deliver
// its own result until the waiting one is taken.
`include "sntp_offset_filter_defines.svh"

module sntp_offset_filter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  sof_pkg::req_item_t req_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sof_pkg::rsp_item_t rsp_item
);
    import sof_pkg::*;

    typedef enum logic [20:0] {
        S_IDLE   = 21'h000001,
        S_CHECK  = 21'h000002,
        S_PROC   = 21'h000004,
        S_RTT    = 21'h000008,
        S_INCON  = 21'h000010,
        S_UA     = 21'h000020,
        S_UB     = 21'h000040,
        S_SUM    = 21'h000080,
        S_NEG    = 21'h000100,
        S_DLY    = 21'h000200,
        S_FIN    = 21'h000400,
        S_SCAN   = 21'h000800,
        S_PICK   = 21'h001000,
        S_SORT   = 21'h002000,
        S_MED1   = 21'h004000,
        S_MED2   = 21'h008000,
        S_SPREAD = 21'h010000,
        S_SPNEG  = 21'h020000,
        S_UNC1   = 21'h040000,
        S_UNC2   = 21'h080000,
        S_OUT    = 21'h100000
    } state_t;

    state_t            state_reg, state_next;
    req_item_t         req_reg, req_next;
    rsp_item_t         res_reg, res_next;
    rsp_item_t         rsp_item_reg, rsp_item_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [63:0]       proc_reg, proc_next;
    logic [63:0]       rtt_reg, rtt_next;
    logic [63:0]       t0_reg, t0_next;
    logic [63:0]       err_reg, err_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  best_reg, best_next;
    logic [62:0]       best_dly_reg, best_dly_next;
    logic              have_reg, have_next;
    logic [MAX_SAMPLES-1:0] taken_reg, taken_next;
    logic [SEL_W-1:0]  sel_reg, sel_next;
    logic [SEL_W-1:0]  k_reg, k_next;
    logic [SIDX_W-1:0] j_reg, j_next;
    logic [SIDX_W-1:0] p_reg, p_next;
    logic [47:0]       maxdisp_reg, maxdisp_next;
    logic [62:0]       first_dly_reg, first_dly_next;
    logic [47:0]       first_rt_reg, first_rt_next;
    logic [63:0]       med_reg, med_next;
    logic [63:0]       spread_reg, spread_next;
    logic [63:0]       errs_reg [SELECT_COUNT];
    logic [63:0]       errs_next [SELECT_COUNT];

    alu_req_t          alu_req;
    logic [64:0]       alu_res;
    logic              st_clear;
    logic              st_wr;
    sample_t           st_wr_data;
    logic [IDX_W-1:0]  st_rd_addr;
    sample_t           st_rd_data;
    logic [CNT_W-1:0]  count;
    logic [62:0]       dly_val;
    logic [63:0]       unc_val;
    logic [SIDX_W-1:0] mid_idx;
    logic [SIDX_W-1:0] lo_idx;
    logic [SIDX_W-1:0] k_idx;
    logic [SIDX_W-1:0] j1_idx;

    sof_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    sof_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (st_clear),
        .wr_en   (st_wr),
        .wr_data (st_wr_data),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data),
        .count   (count)
    );

    assign mid_idx    = SIDX_W'(sel_reg >> 1);
    assign lo_idx     = sel_reg[0] ? mid_idx : mid_idx - SIDX_W'(1);
    assign k_idx      = k_reg[SIDX_W-1:0];
    assign j1_idx     = j_reg + SIDX_W'(1);
    assign st_rd_addr = (state_reg == S_PICK) ? best_reg : i_reg;
    assign req_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_item   = rsp_item_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        rsp_item_next  = rsp_item_reg;
        rsp_valid_next = rsp_valid_reg;
        proc_next      = proc_reg;
        rtt_next       = rtt_reg;
        t0_next        = t0_reg;
        err_next       = err_reg;
        i_next         = i_reg;
        best_next      = best_reg;
        best_dly_next  = best_dly_reg;
        have_next      = have_reg;
        taken_next     = taken_reg;
        sel_next       = sel_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        p_next         = p_reg;
        maxdisp_next   = maxdisp_reg;
        first_dly_next = first_dly_reg;
        first_rt_next  = first_rt_reg;
        med_next       = med_reg;
        spread_next    = spread_reg;
        errs_next      = errs_reg;
        alu_req        = '{sub: 1'b0, a: '0, b: '0};
        st_clear       = 1'b0;
        st_wr          = 1'b0;
        st_wr_data     = '0;
        dly_val        = '0;
        unc_val        = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req_item;
                    res_next = '0;
                    case (req_item.opcode)
                        OP_CLEAR:
                        begin
                            st_clear        = 1'b1;
                            res_next.status = ST_CLEARED;
                            state_next      = S_OUT;
                        end
                        OP_REPLY: state_next = S_CHECK;
                        default:  state_next = S_FIN;
                    endcase
                end
            end
            S_CHECK:
            begin
                if (req_reg.header_flags[7:6] == LEAP_ALARM
                    || req_reg.header_flags[5:3] < MIN_VERSION
                    || req_reg.header_flags[2:0] != MODE_SERVER
                    || req_reg.stratum == 8'd0 || req_reg.stratum > STRATUM_MAX)
                begin
                    res_next.status = ST_BAD_HEADER;
                    state_next      = S_OUT;
                end
                else if (req_reg.originate_stamp != req_reg.local_send_time)
                begin
                    res_next.status = ST_ORIG_MISMATCH;
                    state_next      = S_OUT;
                end
                else if (req_reg.receive_stamp == 64'd0 || req_reg.transmit_stamp == 64'd0)
                begin
                    res_next.status = ST_ZERO_STAMPS;
                    state_next      = S_OUT;
                end
                else
                begin
                    state_next = S_PROC;
                end
            end
            S_PROC:
            begin
                alu_req    = '{sub: 1'b1, a: zx(req_reg.transmit_stamp),
                               b: zx(req_reg.receive_stamp)};
                proc_next  = alu_res[63:0];
                state_next = S_RTT;
            end
            S_RTT:
            begin
                alu_req    = '{sub: 1'b1, a: zx(req_reg.local_receive_time),
                               b: zx(req_reg.local_send_time)};
                rtt_next   = alu_res[63:0];
                state_next = S_INCON;
            end
            S_INCON:
            begin
                alu_req = '{sub: 1'b0, a: sx(proc_reg), b: zx(MS_UNITS)};
                if (alu_res[64] || rtt_reg[63])
                begin
                    res_next.status = ST_INCONSISTENT;
                    state_next      = S_OUT;
                end
                else if (32'(count) >= MAX_SAMPLES)
                begin
                    res_next.status = ST_FULL;
                    state_next      = S_OUT;
                end
                else
                begin
                    state_next = S_UA;
                end
            end
            S_UA:
            begin
                alu_req    = '{sub: 1'b1, a: zx(req_reg.receive_stamp),
                               b: zx(req_reg.local_send_time)};
                t0_next    = alu_res[63:0];
                state_next = S_UB;
            end
            S_UB:
            begin
                alu_req    = '{sub: 1'b1, a: zx(req_reg.transmit_stamp),
                               b: zx(req_reg.local_receive_time)};
                err_next   = alu_res[63:0];
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // exact 65-bit sum, floor halve
                alu_req    = '{sub: 1'b0, a: sx(t0_reg), b: sx(err_reg)};
                t0_next    = alu_res[64:1];
                state_next = S_NEG;
            end
            S_NEG:
            begin
                alu_req = '{sub: 1'b1, a: '0, b: sx(t0_reg)};
                if (!alu_res[64] && alu_res[63])
                begin
                    err_next = {1'b0, MAX63};
                end
                else
                begin
                    err_next = alu_res[63:0];
                end
                state_next = S_DLY;
            end
            S_DLY:
            begin
                alu_req = '{sub: 1'b1, a: sx(rtt_reg), b: sx(proc_reg)};
                if (alu_res[64] || alu_res == 65'd0)
                begin
                    dly_val = '0;
                end
                else if (alu_res[63])
                begin
                    dly_val = MAX63;
                end
                else
                begin
                    dly_val = alu_res[62:0];
                end
                st_wr                  = 1'b1;
                st_wr_data             = '{offset: err_reg, delay: dly_val,
                                           dispersion: {req_reg.root_dispersion, 16'h0000},
                                           round_trip: req_reg.round_trip_time};
                res_next.status        = ST_STORED;
                res_next.clock_error   = err_reg;
                res_next.network_delay = dly_val;
                state_next             = S_OUT;
            end
            S_FIN:
            begin
                if (count == '0)
                begin
                    res_next.status = ST_NO_SAMPLES;
                    state_next      = S_OUT;
                end
                else
                begin
                    if (32'(count) < SELECT_COUNT)
                    begin
                        sel_next = SEL_W'(count);
                    end
                    else
                    begin
                        sel_next = SEL_W'(SELECT_COUNT);
                    end
                    i_next       = '0;
                    k_next       = '0;
                    have_next    = 1'b0;
                    taken_next   = '0;
                    maxdisp_next = '0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!taken_reg[i_reg])
                begin
                    alu_req = '{sub: 1'b1, a: zx(64'(st_rd_data.delay)),
                                b: zx(64'(best_dly_reg))};
                    if (!have_reg || alu_res[64])
                    begin
                        best_next     = i_reg;
                        best_dly_next = st_rd_data.delay;
                        have_next     = 1'b1;
                    end
                end
                if (CNT_W'(i_reg) + CNT_W'(1) == count)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    i_next = i_reg + IDX_W'(1);
                end
            end
            S_PICK:
            begin
                taken_next[best_reg] = 1'b1;
                errs_next[k_idx]     = st_rd_data.offset;
                alu_req = '{sub: 1'b1, a: zx(64'(st_rd_data.dispersion)),
                            b: zx(64'(maxdisp_reg))};
                if (!alu_res[64])
                begin
                    maxdisp_next = st_rd_data.dispersion;
                end
                if (k_reg == '0)
                begin
                    first_dly_next = st_rd_data.delay;
                    first_rt_next  = st_rd_data.round_trip;
                end
                have_next = 1'b0;
                i_next    = '0;
                k_next    = k_reg + SEL_W'(1);
                if (k_reg + SEL_W'(1) == sel_reg)
                begin
                    j_next     = '0;
                    p_next     = '0;
                    state_next = S_SORT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SORT:
            begin
                if (sel_reg == SEL_W'(1))
                begin
                    state_next = S_MED1;
                end
                else
                begin
                    alu_req = '{sub: 1'b1, a: sx(errs_reg[j1_idx]), b: sx(errs_reg[j_reg])};
                    if (alu_res[64])
                    begin
                        errs_next[j_reg]  = errs_reg[j1_idx];
                        errs_next[j1_idx] = errs_reg[j_reg];
                    end
                    if (SEL_W'(j_reg) + SEL_W'(2) == sel_reg)
                    begin
                        j_next = '0;
                        if (SEL_W'(p_reg) + SEL_W'(2) == sel_reg)
                        begin
                            state_next = S_MED1;
                        end
                        else
                        begin
                            p_next = p_reg + SIDX_W'(1);
                        end
                    end
                    else
                    begin
                        j_next = j1_idx;
                    end
                end
            end
            S_MED1:
            begin
                if (sel_reg[0])
                begin
                    med_next    = errs_reg[mid_idx];
                    spread_next = '0;
                    k_next      = '0;
                    state_next  = S_SPREAD;
                end
                else
                begin
                    alu_req    = '{sub: 1'b1, a: sx(errs_reg[mid_idx]), b: sx(errs_reg[lo_idx])};
                    t0_next    = alu_res[64:1];
                    state_next = S_MED2;
                end
            end
            S_MED2:
            begin
                alu_req     = '{sub: 1'b0, a: zx(errs_reg[lo_idx]), b: zx(t0_reg)};
                med_next    = alu_res[63:0];
                spread_next = '0;
                k_next      = '0;
                state_next  = S_SPREAD;
            end
            S_SPREAD, S_SPNEG:
            begin
                if (state_reg == S_SPREAD)
                begin
                    alu_req = '{sub: 1'b1, a: sx(errs_reg[k_idx]), b: sx(med_reg)};
                end
                else
                begin
                    alu_req = '{sub: 1'b1, a: sx(med_reg), b: sx(errs_reg[k_idx])};
                end
                if (alu_res[64])
                begin
                    state_next = S_SPNEG;
                end
                else
                begin
                    if (alu_res[63:0] > spread_reg)
                    begin
                        spread_next = alu_res[63:0];
                    end
                    if (k_reg + SEL_W'(1) == sel_reg)
                    begin
                        state_next = S_UNC1;
                    end
                    else
                    begin
                        k_next     = k_reg + SEL_W'(1);
                        state_next = S_SPREAD;
                    end
                end
            end
            S_UNC1:
            begin
                alu_req = '{sub: 1'b0, a: zx(64'(first_dly_reg >> 1)),
                            b: zx(spread_reg[63] ? {1'b0, MAX63} : spread_reg)};
                if (alu_res[64] || alu_res[63])
                begin
                    t0_next = {1'b0, MAX63};
                end
                else
                begin
                    t0_next = alu_res[63:0];
                end
                state_next = S_UNC2;
            end
            S_UNC2:
            begin
                alu_req = '{sub: 1'b0, a: zx(t0_reg), b: zx(64'(maxdisp_reg))};
                if (alu_res[64] || alu_res[63])
                begin
                    unc_val = {1'b0, MAX63};
                end
                else if (alu_res[63:0] < MS_UNITS)
                begin
                    unc_val = MS_UNITS;
                end
                else
                begin
                    unc_val = alu_res[63:0];
                end
                res_next.status          = ST_READY;
                res_next.clock_error     = med_reg;
                res_next.network_delay   = first_dly_reg;
                res_next.uncertainty     = unc_val[62:0];
                res_next.best_round_trip = first_rt_reg;
                state_next               = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_item_next              = res_reg;
                    rsp_item_next.sample_count = 3'(count);
                    rsp_valid_next             = 1'b1;
                    state_next                 = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        res_reg       <= res_next;
        rsp_item_reg  <= rsp_item_next;
        proc_reg      <= proc_next;
        rtt_reg       <= rtt_next;
        t0_reg        <= t0_next;
        err_reg       <= err_next;
        i_reg         <= i_next;
        best_reg      <= best_next;
        best_dly_reg  <= best_dly_next;
        have_reg      <= have_next;
        taken_reg     <= taken_next;
        sel_reg       <= sel_next;
        k_reg         <= k_next;
        j_reg         <= j_next;
        p_reg         <= p_next;
        maxdisp_reg   <= maxdisp_next;
        first_dly_reg <= first_dly_next;
        first_rt_reg  <= first_rt_next;
        med_reg       <= med_next;
        spread_reg    <= spread_next;
        errs_reg      <= errs_next;
    end

    `SOF_ASSERT_NEXT(a_accept_goes_busy, req_valid && !req_stall, state_reg != S_IDLE)
    `SOF_ASSERT_NEXT(a_out_delivers, state_reg == S_OUT && !rsp_stall,
        rsp_valid_reg && state_reg == S_IDLE)
    `SOF_ASSERT_SAME(a_stored_counts, rsp_valid_reg && rsp_item_reg.status == ST_STORED,
        rsp_item_reg.sample_count != 3'd0)
    `SOF_ASSERT_SAME(a_unc_floor, rsp_valid_reg && rsp_item_reg.status == ST_READY,
        rsp_item_reg.uncertainty >= MS_UNITS[62:0])

endmodule

// ===== rtl/sof_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sof_alu
// shared 65-bit add and subtract unit used by the sequencer's arithmetic steps
// ----------------------------------------------------------------------------
module sof_alu (
    input  sof_pkg::alu_req_t req,
    output logic [64:0]       res
);
    import sof_pkg::*;

    logic [64:0] b_op;

    assign b_op = req.sub ? ~req.b : req.b;
    assign res  = req.a + b_op + 65'(req.sub);

endmodule

// ===== rtl/sof_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sof_store
// sample register file with fill count, one write and one read port
// ----------------------------------------------------------------------------
module sof_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        wr_en,
    input  sof_pkg::sample_t            wr_data,
    input  logic [sof_pkg::IDX_W-1:0]   rd_addr,
    output sof_pkg::sample_t            rd_data,
    output logic [sof_pkg::CNT_W-1:0]   count
);
    import sof_pkg::*;

    sample_t          mem [MAX_SAMPLES];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (clear)
        begin
            count_next = '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= wr_data;
        end
    end

    assign rd_data = mem[rd_addr];
    assign count   = count_reg;

endmodule
